// ----- sv/ses_pkg.sv -----
// Package: shared constants and types of the sequential elimination selector.
`default_nettype none
package ses_pkg;
   localparam int MAX_ALT  = 16;
   localparam int SUM_W    = 48;
   localparam int IDX_W    = 4;
   localparam int CNT_W    = 5;
   localparam int SMP_W    = 32;
   localparam int THR_W    = 48;
   localparam int LAM_W    = 32;
   localparam int RND_W    = 16;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 64;
   localparam int RESET_NUM = 2;

   localparam logic [1:0] REG_NUM = 2'd0;
   localparam logic [1:0] REG_THR = 2'd1;
   localparam logic [1:0] REG_LAM = 2'd2;

   // running leader handed from cell to cell
   typedef struct packed {
      logic                    valid;
      logic [IDX_W-1:0]        idx;
      logic signed [SUM_W-1:0] sum;
   } scan_type;

   // broadcast controls from the sequencer to every cell
   typedef struct packed {
      logic                    add_en;
      logic [IDX_W-1:0]        sel_idx;
      logic signed [SMP_W-1:0] sample;
      logic                    start;
      logic [CNT_W-1:0]        num;
      logic                    prune;
      logic signed [SUM_W-1:0] lead_sum;
      logic [THR_W-1:0]        slack;
   } cell_ctrl_type;
endpackage
`default_nettype wire

// ----- sv/ses_if.sv -----
// Interfaces: request and response channels of the selector.
`default_nettype none
interface ses_req_if;
   logic                                valid;
   logic                                ready;
   logic                                mode;
   logic [ses_pkg::IDX_W-1:0]           alt_index;
   logic signed [ses_pkg::SMP_W-1:0]    sample_value;
   logic                                round_end;
   modport source (output valid, mode, alt_index, sample_value, round_end, input ready);
   modport sink (input valid, mode, alt_index, sample_value, round_end, output ready);
endinterface

interface ses_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          accepted;
   logic                          round_closed;
   logic                          finished;
   logic [ses_pkg::CNT_W-1:0]     active_count;
   logic [ses_pkg::IDX_W-1:0]     leader_index;
   logic [ses_pkg::MAX_ALT-1:0]   active_mask;
   logic [ses_pkg::RND_W-1:0]     round_number;
   modport source (output valid, accepted, round_closed, finished, active_count,
                   leader_index, active_mask, round_number, input ready);
   modport sink (input valid, accepted, round_closed, finished, active_count,
                 leader_index, active_mask, round_number, output ready);
endinterface
`default_nettype wire

// ----- sv/sequential_elimination_selector.sv -----
// Top level: sequencer, configuration registers and the row of selector cells.
// Each accepted beat yields one response beat. A start or plain sample beat
// passes the sequencer through accept, apply and emit; its response is
// registered in the emit step, which waits while an earlier response has not
// been taken. A sample beat with round_end set, while the selection is not
// finished, also runs the screening pass: the running leader ripples through
// the row of 16 cells, one cell a cycle, while the slack a - r*lambda is
// formed alongside; the drop step follows, then emit. A new request beat is
// taken as soon as the sequencer is back in idle, even while the previous
// response still waits. Configuration sits on an APB port at byte address 8*i
// (64-bit data); num_alternatives takes effect at the next start beat, the
// slack registers at each screening.
`default_nettype none
module sequential_elimination_selector (
   input  wire logic                         clock,
   input  wire logic                         reset,
   ses_req_if.sink                           req,
   ses_rsp_if.source                         rsp,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [ses_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [ses_pkg::DATA_W-1:0]   pwdata,
   output      logic [ses_pkg::DATA_W-1:0]   prdata,
   output      logic                         pready
);
   typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_SCAN, ST_PRUNE, ST_EMIT} state_type;

   state_type                         state_ff;
   logic [ses_pkg::CNT_W-1:0]         num_ff;
   logic [ses_pkg::THR_W-1:0]         thr_ff;
   logic [ses_pkg::LAM_W-1:0]         lam_ff;

   // latched request beat
   logic                              mode_ff, rend_ff;
   logic [ses_pkg::IDX_W-1:0]         idx_ff;
   logic signed [ses_pkg::SMP_W-1:0]  smp_ff;

   logic [ses_pkg::RND_W-1:0]         rounds_ff;
   logic [ses_pkg::IDX_W-1:0]         leader_ff;
   logic                              done_ff, done_in;
   logic                              acc_ff, closed_ff;
   logic [ses_pkg::CNT_W-1:0]         scan_cnt_ff;
   logic [ses_pkg::THR_W-1:0]         prod_ff, slack_ff;

   logic                              rsp_valid_ff, rsp_acc_ff, rsp_closed_ff, rsp_fin_ff;
   logic [ses_pkg::CNT_W-1:0]         rsp_cnt_ff;
   logic [ses_pkg::IDX_W-1:0]         rsp_lead_ff;
   logic [ses_pkg::MAX_ALT-1:0]       rsp_mask_ff;
   logic [ses_pkg::RND_W-1:0]         rsp_rnd_ff;

   logic [ses_pkg::MAX_ALT-1:0]       act_vec;
   ses_pkg::scan_type                 chain [ses_pkg::MAX_ALT+1];
   ses_pkg::cell_ctrl_type            ctrl;
   logic [ses_pkg::CNT_W-1:0]         num_norm, act_cnt;
   logic                              live, emit_go;
   logic [1:0]                        wr_idx;

   // clamp the configured count to 1..MAX_ALT
   always_comb begin
      if (num_ff == '0)
         num_norm = ses_pkg::CNT_W'(1);
      else if (num_ff > ses_pkg::CNT_W'(ses_pkg::MAX_ALT))
         num_norm = ses_pkg::CNT_W'(ses_pkg::MAX_ALT);
      else
         num_norm = num_ff;
   end

   assign live    = !mode_ff && !done_ff;
   assign act_cnt = ses_pkg::CNT_W'($countones(act_vec));
   assign emit_go = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      ctrl.add_en   = (state_ff == ST_EXEC) && live;
      ctrl.sel_idx  = idx_ff;
      ctrl.sample   = smp_ff;
      ctrl.start    = (state_ff == ST_EXEC) && mode_ff;
      ctrl.num      = num_norm;
      ctrl.prune    = (state_ff == ST_PRUNE) && chain[ses_pkg::MAX_ALT].valid;
      ctrl.lead_sum = chain[ses_pkg::MAX_ALT].sum;
      ctrl.slack    = slack_ff;
   end

   // the scan enters the row with no leader yet
   assign chain[0] = '0;

   for (genvar g = 0; g < ses_pkg::MAX_ALT; g++) begin : g_cell
      ses_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_id  (ses_pkg::IDX_W'(g)),
         .ctrl     (ctrl),
         .scan_in  (chain[g]),
         .scan_out (chain[g+1]),
         .active   (act_vec[g])
      );
   end

   // close the round with a single survivor
   assign done_in = done_ff || (closed_ff && act_cnt == ses_pkg::CNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         num_ff       <= ses_pkg::CNT_W'(ses_pkg::RESET_NUM);
         thr_ff       <= '0;
         lam_ff       <= '0;
         rounds_ff    <= '0;
         leader_ff    <= '0;
         done_ff      <= (ses_pkg::RESET_NUM == 1);
         scan_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (psel && penable && pwrite) begin
            case (wr_idx)
               ses_pkg::REG_NUM: num_ff <= pwdata[ses_pkg::CNT_W-1:0];
               ses_pkg::REG_THR: thr_ff <= pwdata[ses_pkg::THR_W-1:0];
               ses_pkg::REG_LAM: lam_ff <= pwdata[ses_pkg::LAM_W-1:0];
               default: ;
            endcase
         end
         // load a new response beat, or drop the one taken by the sink
         if (emit_go)
            rsp_valid_ff <= 1'b1;
         else if (rsp.ready)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req.valid)
                  state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               if (mode_ff) begin
                  rounds_ff <= '0;
                  leader_ff <= '0;
                  done_ff   <= (num_norm == ses_pkg::CNT_W'(1));
                  state_ff  <= ST_EMIT;
               end else if (live && rend_ff) begin
                  if (rounds_ff != '1)
                     rounds_ff <= rounds_ff + 1'b1;
                  scan_cnt_ff <= '0;
                  state_ff    <= ST_SCAN;
               end else begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_SCAN: begin
               // advance the leader one cell per cycle
               scan_cnt_ff <= scan_cnt_ff + 1'b1;
               if (scan_cnt_ff == ses_pkg::CNT_W'(ses_pkg::MAX_ALT - 1))
                  state_ff <= ST_PRUNE;
            end
            ST_PRUNE: begin
               if (chain[ses_pkg::MAX_ALT].valid)
                  leader_ff <= chain[ses_pkg::MAX_ALT].idx;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (emit_go) begin
                  done_ff  <= done_in;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // payload registers: latch the beat, form the slack, load the response
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req.valid) begin
         mode_ff <= req.mode;
         idx_ff  <= req.alt_index;
         smp_ff  <= req.sample_value;
         rend_ff <= req.round_end;
      end
      if (state_ff == ST_EXEC) begin
         acc_ff    <= live && act_vec[idx_ff];
         closed_ff <= live && rend_ff;
      end
      prod_ff  <= {{ses_pkg::LAM_W{1'b0}}, rounds_ff} * {{ses_pkg::RND_W{1'b0}}, lam_ff};
      slack_ff <= (thr_ff > prod_ff) ? thr_ff - prod_ff : '0;
      if (emit_go) begin
         rsp_acc_ff    <= acc_ff;
         rsp_closed_ff <= closed_ff;
         rsp_fin_ff    <= done_in;
         rsp_cnt_ff    <= act_cnt;
         rsp_lead_ff   <= leader_ff;
         rsp_mask_ff   <= act_vec;
         rsp_rnd_ff    <= rounds_ff;
      end
   end

   assign wr_idx    = paddr[ses_pkg::ADDR_W-1:3];
   assign pready    = 1'b1;
   assign req.ready = (state_ff == ST_IDLE);

   always_comb begin
      case (wr_idx)
         ses_pkg::REG_NUM: prdata = ses_pkg::DATA_W'(num_ff);
         ses_pkg::REG_THR: prdata = ses_pkg::DATA_W'(thr_ff);
         ses_pkg::REG_LAM: prdata = ses_pkg::DATA_W'(lam_ff);
         default:          prdata = '0;
      endcase
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.accepted     = rsp_acc_ff;
   assign rsp.round_closed = rsp_closed_ff;
   assign rsp.finished     = rsp_fin_ff;
   assign rsp.active_count = rsp_cnt_ff;
   assign rsp.leader_index = rsp_lead_ff;
   assign rsp.active_mask  = rsp_mask_ff;
   assign rsp.round_number = rsp_rnd_ff;
endmodule
`default_nettype wire

// ----- sv/ses_cell.sv -----
// Cell: one alternative's sum and active flag, plus one stage of the leader scan.
`default_nettype none
module ses_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [ses_pkg::IDX_W-1:0]     cell_id,
   input  wire ses_pkg::cell_ctrl_type        ctrl,
   input  wire ses_pkg::scan_type             scan_in,
   output      ses_pkg::scan_type             scan_out,
   output      logic                          active
);
   logic signed [ses_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic                             act_ff, act_in;
   ses_pkg::scan_type                scan_ff, scan_in_nx;
   logic signed [ses_pkg::SUM_W:0]   ext;
   logic [ses_pkg::SUM_W-1:0]        gap;

   always_comb begin
      ext = {sum_ff[ses_pkg::SUM_W-1], sum_ff}
          + {{(ses_pkg::SUM_W+1-ses_pkg::SMP_W){ctrl.sample[ses_pkg::SMP_W-1]}}, ctrl.sample};
      gap = ctrl.lead_sum - sum_ff;
      sum_in = sum_ff;
      act_in = act_ff;
      if (ctrl.start) begin
         sum_in = '0;
         act_in = ({1'b0, cell_id} < ctrl.num);
      end else if (ctrl.add_en && act_ff && ctrl.sel_idx == cell_id) begin
         if (ext[ses_pkg::SUM_W] != ext[ses_pkg::SUM_W-1])
            sum_in = ext[ses_pkg::SUM_W] ? {1'b1, {(ses_pkg::SUM_W-1){1'b0}}}
                                         : {1'b0, {(ses_pkg::SUM_W-1){1'b1}}};
         else
            sum_in = ext[ses_pkg::SUM_W-1:0];
      end else if (ctrl.prune && act_ff && gap > ctrl.slack) begin
         act_in = 1'b0;
      end
      // keep the incoming leader unless this cell beats it strictly
      scan_in_nx = scan_in;
      if (act_ff && (!scan_in.valid || sum_ff > scan_in.sum)) begin
         scan_in_nx.valid = 1'b1;
         scan_in_nx.idx   = cell_id;
         scan_in_nx.sum   = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         act_ff <= ({1'b0, cell_id} < ses_pkg::CNT_W'(ses_pkg::RESET_NUM));
         scan_ff.valid <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         act_ff  <= act_in;
         scan_ff.valid <= scan_in_nx.valid;
      end
      scan_ff.idx <= scan_in_nx.idx;
      scan_ff.sum <= scan_in_nx.sum;
   end

   assign scan_out = scan_ff;
   assign active   = act_ff;
endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench of the sequential elimination selector: predictor, stimulus and checks.
`timescale 1ns / 100ps
`default_nettype none

import ses_pkg::*;

typedef struct {
   bit            accepted;
   bit            round_closed;
   bit            finished;
   bit [CNT_W-1:0] active_count;
   bit [IDX_W-1:0] leader_index;
   bit [MAX_ALT-1:0] active_mask;
   bit [RND_W-1:0] round_number;
} outcome_t;

// Tracks the selection state and queues the outcome of every accepted beat.
class elimination_predictor;
   bit [CNT_W-1:0]  cfg_num = RESET_NUM;
   bit [THR_W-1:0]  cfg_thr = '0;
   bit [LAM_W-1:0]  cfg_lam = '0;
   longint          sums[MAX_ALT];
   bit [MAX_ALT-1:0] live;
   int              rounds;
   int              leader;
   bit              done;
   outcome_t        pending[$];
   int              errors;
   int              checked;
   int              closes;
   int              finishes;

   function new();
      begin_run();
   endfunction

   function void begin_run();
      int n;
      n = (cfg_num < 1) ? 1 : (cfg_num > MAX_ALT) ? MAX_ALT : cfg_num;
      foreach (sums[i]) begin
         sums[i] = 0;
         live[i] = (i < n);
      end
      rounds = 0;
      leader = 0;
      done = (n == 1);
   endfunction

   function void screen();
      int best;
      longint unsigned drop, slack, gap;
      best = -1;
      if (rounds < 65535) rounds++;
      for (int i = 0; i < MAX_ALT; i++)
         if (live[i] && (best < 0 || sums[i] > sums[best])) best = i;
      if (best < 0) return;
      leader = best;
      drop = longint'(rounds) * longint'(cfg_lam);
      slack = (64'(cfg_thr) > drop) ? 64'(cfg_thr) - drop : 0;
      for (int i = 0; i < MAX_ALT; i++) begin
         if (!live[i] || i == best) continue;
         gap = sums[best] - sums[i];
         if (gap > slack) live[i] = 0;
      end
      if ($countones(live) == 1) done = 1;
   endfunction

   function void note_beat(bit mode, bit [IDX_W-1:0] idx, bit signed [SMP_W-1:0] val,
                           bit re);
      outcome_t o;
      longint hi, s;
      hi = (longint'(1) <<< (SUM_W - 1)) - 1;
      o.accepted = 0;
      o.round_closed = 0;
      if (mode) begin
         begin_run();
      end else if (!done) begin
         if (live[idx]) begin
            s = sums[idx] + longint'(val);
            sums[idx] = (s > hi) ? hi : (s < -hi - 1) ? -hi - 1 : s;
            o.accepted = 1;
         end
         if (re) begin
            screen();
            o.round_closed = 1;
            closes++;
            if (done) finishes++;
         end
      end
      o.finished = done;
      o.active_count = $countones(live);
      o.leader_index = leader;
      o.active_mask = live;
      o.round_number = rounds;
      pending.push_back(o);
   endfunction

   function void field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   function void check_outcome(outcome_t a);
      outcome_t e;
      if (pending.size() == 0) begin
         $display("%0t: response beat with nothing expected", $time);
         errors++;
         return;
      end
      e = pending.pop_front();
      checked++;
      field("accepted", e.accepted, a.accepted);
      field("round_closed", e.round_closed, a.round_closed);
      field("finished", e.finished, a.finished);
      field("active_count", e.active_count, a.active_count);
      field("leader_index", e.leader_index, a.leader_index);
      field("active_mask", e.active_mask, a.active_mask);
      field("round_number", e.round_number, a.round_number);
   endfunction
endclass

module tb_top;
   logic clock = 0;
   logic reset = 1;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic pready;

   ses_req_if req ();
   ses_rsp_if rsp ();

   elimination_predictor model = new();
   int quiet_cycles = 0;
   bit hold_rsp = 0;      // request one long stall of the response side
   bit bursty = 1;        // random idling on/off
   int beats_sent = 0;
   int bias[MAX_ALT];

   sequential_elimination_selector dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   initial begin
      req.valid = 0;
      req.mode = 0;
      req.alt_index = '0;
      req.sample_value = '0;
      req.round_end = 0;
      rsp.ready = 0;
   end

   // Gap length: mostly short, now and then long.
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!bursty) return 0;
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Response side: random ready, plus one long hold when asked.
   initial begin
      int g;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp.ready = 0;
            repeat (300) @(negedge clock);
            hold_rsp = 0;
         end
         g = pick_gap();
         rsp.ready = (g == 0);
         @(negedge clock);
         if (g > 1) repeat (g - 1) @(negedge clock);
      end
   end

   // Sample the response at the rising edge.
   always @(posedge clock) begin
      outcome_t a;
      if (!reset && rsp.valid && rsp.ready) begin
         a.accepted = rsp.accepted;
         a.round_closed = rsp.round_closed;
         a.finished = rsp.finished;
         a.active_count = rsp.active_count;
         a.leader_index = rsp.leader_index;
         a.active_mask = rsp.active_mask;
         a.round_number = rsp.round_number;
         model.check_outcome(a);
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) || psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("%0t: watchdog expired, %0d responses outstanding", $time,
                  model.pending.size());
         $display("simulation failed");
         $finish;
      end
   end

   // Drive one request beat and wait for the handshake; leave valid high unless a gap is drawn.
   task automatic send(bit mode, bit [IDX_W-1:0] idx, bit [SMP_W-1:0] val, bit re);
      int g;
      @(negedge clock);
      req.valid = 1;
      req.mode = mode;
      req.alt_index = idx;
      req.sample_value = val;
      req.round_end = re;
      do @(posedge clock); while (!req.ready);
      model.note_beat(mode, idx, val, re);
      beats_sent++;
      g = pick_gap();
      if (g > 0) begin
         @(negedge clock);
         req.valid = 0;
         req.sample_value = $urandom();
         if (g > 1) repeat (g - 1) @(negedge clock);
      end
   endtask

   // Hold until every response is back, then let the screening pipe drain.
   task automatic drain();
      @(negedge clock);
      req.valid = 0;
      while (model.pending.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] reg_idx, logic [DATA_W-1:0] value);
      @(negedge clock);
      psel = 1;
      pwrite = 1;
      penable = 0;
      paddr = {reg_idx, 3'b000};
      pwdata = value;
      @(negedge clock);
      penable = 1;
      do @(posedge clock); while (!pready);
      case (reg_idx)
         REG_NUM: model.cfg_num = value[CNT_W-1:0];
         REG_THR: model.cfg_thr = value[THR_W-1:0];
         default: model.cfg_lam = value[LAM_W-1:0];
      endcase
      @(negedge clock);
      psel = 0;
      penable = 0;
      pwrite = 0;
   endtask

   function bit [SMP_W-1:0] draw_sample(int idx);
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return 32'h7fff_ffff;
      if (r < 8) return 32'h8000_0000;
      if (r < 14) return $urandom();
      return bias[idx] + $signed($urandom_range(0, 1 << 19)) - (1 << 18);
   endfunction

   // One run: configure, start, then well-formed rounds mixed with noise.
   task automatic run_phase(int num, logic [THR_W-1:0] thr, logic [LAM_W-1:0] lam, int beats);
      int n_eff, in_round, round_len, idx, r;
      drain();
      csr_write(REG_NUM, num);
      csr_write(REG_THR, thr);
      csr_write(REG_LAM, lam);
      n_eff = (num < 1) ? 1 : (num > MAX_ALT) ? MAX_ALT : num;
      foreach (bias[i]) bias[i] = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      send(1, $urandom(), $urandom(), $urandom());
      in_round = 0;
      round_len = $urandom_range(1, 2 * n_eff);
      for (int k = 0; k < beats; k++) begin
         r = $urandom_range(0, 99);
         if (r < 3 || (model.done && r < 40)) begin
            send(1, $urandom(), $urandom(), $urandom());
            in_round = 0;
         end else if (r < 10) begin
            send(0, $urandom(), $urandom(), $urandom_range(0, 1));
         end else begin
            idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_ALT - 1)
                                               : $urandom_range(0, n_eff - 1);
            in_round++;
            if (in_round >= round_len) begin
               send(0, idx, draw_sample(idx), 1);
               in_round = 0;
               round_len = $urandom_range(1, 2 * n_eff);
            end else begin
               send(0, idx, draw_sample(idx), 0);
            end
         end
      end
   endtask

   initial begin
      int wait_cycles;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: reset state, extremes, inactive and out-of-range indexes.
      send(0, 0, 32'h7fff_ffff, 0);
      send(0, 1, 32'h8000_0000, 0);
      send(0, 15, 32'h1234_5678, 0);
      send(0, 2, 32'h0000_0001, 1);
      send(0, 0, 32'h0001_0000, 0);
      send(1, 4'hf, 32'hffff_ffff, 1);
      send(0, 1, 32'h0000_0000, 1);
      drain();
      csr_write(REG_NUM, 16);
      csr_write(REG_THR, 48'hffff_ffff_ffff);
      csr_write(REG_LAM, 32'hffff_ffff);
      send(1, 0, 0, 0);
      for (int i = 0; i < MAX_ALT; i++) send(0, i, (i == 3) ? 32'h7fff_ffff : i, i == 15);
      send(0, 9, 32'h8000_0000, 1);
      drain();
      csr_write(REG_NUM, 1);
      send(1, 0, 0, 0);
      send(0, 0, 32'h0001_0000, 1);
      drain();
      csr_write(REG_NUM, 0);
      send(1, 0, 0, 0);
      send(0, 0, 5, 1);

      // Random runs over a spread of settings.
      run_phase(2, 0, 0, 100);
      // back up the block while requests keep coming
      drain();
      bursty = 0;
      hold_rsp = 1;
      for (int k = 0; k < 80; k++) send(0, k % 2, $urandom(), (k % 4) == 3);
      bursty = 1;
      run_phase(16, 48'h40_0000, 32'h1_0000, 100);
      run_phase(31, 48'hffff_ffff_ffff, 32'hffff_ffff, 120);
      run_phase(17, 48'h0, 32'h0, 100);
      for (int p = 0; p < 9; p++)
         run_phase($urandom_range(2, 16), $urandom_range(0, 1 << 24),
                   $urandom_range(0, 1 << 20), 120);

      @(negedge clock);
      req.valid = 0;
      wait_cycles = 0;
      while (model.pending.size() != 0 && wait_cycles < 20000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (40) @(negedge clock);
      if (model.pending.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, model.pending.size());
         model.errors++;
      end
      $display("Covered %0d request beats, %0d responses checked, %0d screenings,",
               beats_sent, model.checked, model.closes);
      $display("%0d selections finished, long response stall and drain pauses.",
               model.finishes);
      if (model.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

`default_nettype wire

// ----- sequential_elimination_selector.f -----
sv/ses_pkg.sv
sv/ses_if.sv
sv/ses_cell.sv
sv/sequential_elimination_selector.sv
sim/tb_top.sv
